>>> rtl/i2cram_pkg.sv
// Shared types and constants for the I2C register access master.
// No dependencies; used by every module of the block.
package i2cram_pkg;

	localparam logic [4:0] P_IDLE     = 5'd0;
	localparam logic [4:0] P_ST_A     = 5'd1;
	localparam logic [4:0] P_ST_B     = 5'd2;
	localparam logic [4:0] P_ST_C     = 5'd3;
	localparam logic [4:0] P_RS_PRE   = 5'd4;
	localparam logic [4:0] P_TX_LOW   = 5'd5;
	localparam logic [4:0] P_TX_HIGH  = 5'd6;
	localparam logic [4:0] P_ACK_REL  = 5'd7;
	localparam logic [4:0] P_ACK_HIGH = 5'd8;
	localparam logic [4:0] P_ACK_POLL = 5'd9;
	localparam logic [4:0] P_RX_LOW   = 5'd10;
	localparam logic [4:0] P_RX_HIGH  = 5'd11;
	localparam logic [4:0] P_RA_LOW   = 5'd12;
	localparam logic [4:0] P_RA_HIGH  = 5'd13;
	localparam logic [4:0] P_SP_A     = 5'd14;
	localparam logic [4:0] P_SP_B     = 5'd15;
	localparam logic [4:0] P_SP_C     = 5'd16;

	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [1:0] CFG_SHORT_WAIT = 2'd0;
	localparam logic [1:0] CFG_LONG_WAIT  = 2'd1;
	localparam logic [1:0] CFG_ACK_LIMIT  = 2'd2;

	localparam logic [15:0] SHORT_WAIT_RST = 16'd60;
	localparam logic [15:0] LONG_WAIT_RST  = 16'd130;
	localparam logic [7:0]  ACK_LIMIT_RST  = 8'd250;

	localparam logic [7:0] MSB_MASK = 8'h80;

	typedef struct packed {
		logic [15:0] short_wait;
		logic [15:0] long_wait;
		logic [7:0]  ack_limit;
	} cfg_t;

	typedef struct packed {
		logic       scl;
		logic       sda_out;
		logic       sda_drive;
		logic       bus_sel;
		logic       read_valid;
		logic [7:0] read_data;
		logic       read_last;
		logic       ack_error;
		logic       busy_res;
	} res_t;

endpackage

>>> rtl/i2cram_cfg.sv
// Configuration register file: bus delays and acknowledge poll limit.
// Depends on i2cram_pkg.
module i2cram_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	output i2cram_pkg::cfg_t   cfg
);

	i2cram_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_wait <= i2cram_pkg::SHORT_WAIT_RST;
			cfg_q.long_wait  <= i2cram_pkg::LONG_WAIT_RST;
			cfg_q.ack_limit  <= i2cram_pkg::ACK_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				i2cram_pkg::CFG_SHORT_WAIT: cfg_q.short_wait <= cfg_data;
				i2cram_pkg::CFG_LONG_WAIT:  cfg_q.long_wait  <= cfg_data;
				i2cram_pkg::CFG_ACK_LIMIT:  cfg_q.ack_limit  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

endmodule

>>> rtl/i2cram_seq.sv
// Bus sequencer: phase, timing counters and shift state, advanced one tick
// per accepted word. Depends on i2cram_pkg.
module i2cram_seq #(
	parameter int WAIT_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [1:0]         op,
	input  logic               bus,
	input  logic [7:0]         device_addr,
	input  logic [7:0]         register_addr,
	input  logic [7:0]         write_data,
	input  logic [7:0]         read_count,
	input  logic               sda_in,
	input  i2cram_pkg::cfg_t   cfg,
	output i2cram_pkg::res_t   res
);

	localparam int CW = (WAIT_BITS > 16) ? WAIT_BITS : 16;
	localparam logic [CW-1:0] WMAX = CW'({WAIT_BITS{1'b1}});

	logic [4:0]           phase_q;
	logic [WAIT_BITS-1:0] wait_q;
	logic [2:0]           bit_q;
	logic [7:0]           shift_q;
	logic [7:0]           left_q;
	logic [7:0]           poll_q;
	logic                 bus_q;
	logic [7:0]           dev_q;
	logic [7:0]           reg_q;
	logic [7:0]           data_q;
	logic                 rd_q;
	logic                 scl_q;
	logic                 sda_q;
	logic                 err_q;

	logic [4:0]           n_phase;
	logic [WAIT_BITS-1:0] n_wait;
	logic [2:0]           n_bit;
	logic [7:0]           n_shift;
	logic [7:0]           n_left;
	logic [7:0]           n_poll;
	logic                 n_bus;
	logic [7:0]           n_dev;
	logic [7:0]           n_reg;
	logic [7:0]           n_data;
	logic                 n_rd;
	logic                 n_scl;
	logic                 n_sda;
	logic                 n_err;
	logic                 pres_valid;
	logic [7:0]           pres_data;
	logic                 pres_last;
	logic                 go_en;
	logic [4:0]           go_ph;

	logic [CW-1:0]        sw_ext;
	logic [CW-1:0]        lw_ext;
	logic [WAIT_BITS-1:0] sw_dur;
	logic [WAIT_BITS-1:0] lw_dur;

	// zero delay counts as one tick, large values saturate to the counter
	always_comb begin
		sw_ext = CW'(cfg.short_wait);
		lw_ext = CW'(cfg.long_wait);
		if (sw_ext == '0)
			sw_dur = WAIT_BITS'(1);
		else if (sw_ext > WMAX)
			sw_dur = WMAX[WAIT_BITS-1:0];
		else
			sw_dur = sw_ext[WAIT_BITS-1:0];
		if (lw_ext == '0)
			lw_dur = WAIT_BITS'(1);
		else if (lw_ext > WMAX)
			lw_dur = WMAX[WAIT_BITS-1:0];
		else
			lw_dur = lw_ext[WAIT_BITS-1:0];
	end

	always_comb begin
		n_phase = phase_q;
		n_wait  = wait_q;
		n_bit   = bit_q;
		n_shift = shift_q;
		n_left  = left_q;
		n_poll  = poll_q;
		n_bus   = bus_q;
		n_dev   = dev_q;
		n_reg   = reg_q;
		n_data  = data_q;
		n_rd    = rd_q;
		n_scl   = scl_q;
		n_sda   = sda_q;
		n_err   = err_q;
		pres_valid = 1'b0;
		pres_data  = 8'd0;
		pres_last  = 1'b0;
		go_en = 1'b0;
		go_ph = i2cram_pkg::P_IDLE;

		if (phase_q == i2cram_pkg::P_IDLE) begin
			if (op == i2cram_pkg::OP_WRITE || op == i2cram_pkg::OP_READ) begin
				n_bus  = bus;
				n_dev  = device_addr;
				n_reg  = register_addr;
				n_rd   = (op == i2cram_pkg::OP_READ);
				n_data = n_rd ? read_count : write_data;
				n_left = 8'd0;
				n_bit  = 3'd0;
				n_err  = 1'b0;
				go_en  = 1'b1;
				go_ph  = i2cram_pkg::P_ST_A;
			end else begin
				n_scl = 1'b1;
				n_sda = 1'b1;
			end
		end else if (phase_q == i2cram_pkg::P_ACK_POLL) begin
			if (!sda_in) begin
				go_en = 1'b1;
				if (left_q == 8'd0) begin
					n_shift = reg_q;
					n_bit   = 3'd0;
					n_left  = 8'd1;
					go_ph   = i2cram_pkg::P_TX_LOW;
				end else if (left_q == 8'd1) begin
					n_left = 8'd2;
					if (rd_q) begin
						go_ph = i2cram_pkg::P_RS_PRE;
					end else begin
						n_shift = data_q;
						n_bit   = 3'd0;
						go_ph   = i2cram_pkg::P_TX_LOW;
					end
				end else if (rd_q) begin
					n_left  = (data_q != 8'd0) ? data_q : 8'd1;
					n_bit   = 3'd0;
					n_shift = 8'd0;
					go_ph   = i2cram_pkg::P_RX_LOW;
				end else begin
					go_ph = i2cram_pkg::P_SP_A;
				end
			end else if (poll_q >= cfg.ack_limit) begin
				n_err = 1'b1;
				go_en = 1'b1;
				go_ph = i2cram_pkg::P_SP_A;
			end else begin
				n_poll = poll_q + 8'd1;
			end
		end else if (phase_q > i2cram_pkg::P_SP_C) begin
			go_en = 1'b1;
			go_ph = i2cram_pkg::P_IDLE;
		end else if (wait_q > WAIT_BITS'(1)) begin
			n_wait = wait_q - WAIT_BITS'(1);
		end else begin
			go_en = 1'b1;
			case (phase_q)
				i2cram_pkg::P_ST_A: go_ph = i2cram_pkg::P_ST_B;
				i2cram_pkg::P_ST_B: go_ph = i2cram_pkg::P_ST_C;
				i2cram_pkg::P_ST_C: begin
					n_shift = (left_q == 8'd0) ? dev_q : dev_q + 8'd1;
					n_bit   = 3'd0;
					go_ph   = i2cram_pkg::P_TX_LOW;
				end
				i2cram_pkg::P_RS_PRE: go_ph = i2cram_pkg::P_ST_A;
				i2cram_pkg::P_TX_LOW: go_ph = i2cram_pkg::P_TX_HIGH;
				i2cram_pkg::P_TX_HIGH: begin
					if (bit_q == 3'd7) begin
						go_ph = i2cram_pkg::P_ACK_REL;
					end else begin
						n_bit   = bit_q + 3'd1;
						n_shift = {shift_q[6:0], 1'b0};
						go_ph   = i2cram_pkg::P_TX_LOW;
					end
				end
				i2cram_pkg::P_ACK_REL:  go_ph = i2cram_pkg::P_ACK_HIGH;
				i2cram_pkg::P_ACK_HIGH: go_ph = i2cram_pkg::P_ACK_POLL;
				i2cram_pkg::P_RX_LOW:   go_ph = i2cram_pkg::P_RX_HIGH;
				i2cram_pkg::P_RX_HIGH: begin
					n_shift = {shift_q[6:0], sda_in};
					if (bit_q == 3'd7) begin
						pres_valid = 1'b1;
						pres_data  = n_shift;
						pres_last  = (left_q == 8'd1);
						go_ph      = i2cram_pkg::P_RA_LOW;
					end else begin
						n_bit = bit_q + 3'd1;
						go_ph = i2cram_pkg::P_RX_LOW;
					end
				end
				i2cram_pkg::P_RA_LOW: go_ph = i2cram_pkg::P_RA_HIGH;
				i2cram_pkg::P_RA_HIGH: begin
					n_left = left_q - 8'd1;
					if (n_left == 8'd0) begin
						go_ph = i2cram_pkg::P_SP_A;
					end else begin
						n_bit   = 3'd0;
						n_shift = 8'd0;
						go_ph   = i2cram_pkg::P_RX_LOW;
					end
				end
				i2cram_pkg::P_SP_A: go_ph = i2cram_pkg::P_SP_B;
				i2cram_pkg::P_SP_B: go_ph = i2cram_pkg::P_SP_C;
				default:            go_ph = i2cram_pkg::P_IDLE;
			endcase
		end

		// entry actions of the phase being entered
		if (go_en) begin
			n_phase = go_ph;
			n_wait  = sw_dur;
			case (go_ph)
				i2cram_pkg::P_ST_A: begin
					n_scl = 1'b1;
					n_sda = 1'b1;
				end
				i2cram_pkg::P_ST_B: n_sda = 1'b0;
				i2cram_pkg::P_ST_C: n_scl = 1'b0;
				i2cram_pkg::P_RS_PRE: begin
					n_scl = 1'b0;
					n_sda = 1'b1;
				end
				i2cram_pkg::P_TX_LOW: begin
					n_scl = 1'b0;
					n_sda = |(n_shift & i2cram_pkg::MSB_MASK);
				end
				i2cram_pkg::P_TX_HIGH: n_scl = 1'b1;
				i2cram_pkg::P_ACK_REL: begin
					n_scl = 1'b0;
					n_sda = 1'b1;
				end
				i2cram_pkg::P_ACK_HIGH: n_scl = 1'b1;
				i2cram_pkg::P_ACK_POLL: begin
					n_poll = 8'd0;
					n_wait = '0;
				end
				i2cram_pkg::P_RX_LOW: begin
					n_scl  = 1'b0;
					n_sda  = 1'b1;
					n_wait = lw_dur;
				end
				i2cram_pkg::P_RX_HIGH: n_scl = 1'b1;
				i2cram_pkg::P_RA_LOW: begin
					n_scl = 1'b0;
					n_sda = (n_left == 8'd1);
				end
				i2cram_pkg::P_RA_HIGH: n_scl = 1'b1;
				i2cram_pkg::P_SP_A: begin
					n_scl  = 1'b0;
					n_sda  = 1'b0;
					n_wait = WAIT_BITS'(1);
				end
				i2cram_pkg::P_SP_B: n_scl = 1'b1;
				i2cram_pkg::P_SP_C: n_sda = 1'b1;
				default: begin
					n_phase = i2cram_pkg::P_IDLE;
					n_scl   = 1'b1;
					n_sda   = 1'b1;
					n_wait  = '0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cram_pkg::P_IDLE;
			wait_q  <= '0;
			bit_q   <= 3'd0;
			shift_q <= 8'd0;
			left_q  <= 8'd0;
			poll_q  <= 8'd0;
			bus_q   <= 1'b0;
			dev_q   <= 8'd0;
			reg_q   <= 8'd0;
			data_q  <= 8'd0;
			rd_q    <= 1'b0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= n_phase;
			wait_q  <= n_wait;
			bit_q   <= n_bit;
			shift_q <= n_shift;
			left_q  <= n_left;
			poll_q  <= n_poll;
			bus_q   <= n_bus;
			dev_q   <= n_dev;
			reg_q   <= n_reg;
			data_q  <= n_data;
			rd_q    <= n_rd;
			scl_q   <= n_scl;
			sda_q   <= n_sda;
			err_q   <= n_err;
		end
	end

	always_comb begin
		res.scl        = n_scl;
		res.sda_out    = n_sda;
		res.sda_drive  = !(n_phase == i2cram_pkg::P_ACK_REL ||
			n_phase == i2cram_pkg::P_ACK_HIGH || n_phase == i2cram_pkg::P_ACK_POLL ||
			n_phase == i2cram_pkg::P_RX_LOW || n_phase == i2cram_pkg::P_RX_HIGH);
		res.bus_sel    = n_bus;
		res.read_valid = pres_valid;
		res.read_data  = pres_data;
		res.read_last  = pres_last;
		res.ack_error  = n_err;
		res.busy_res   = (n_phase != i2cram_pkg::P_IDLE);
	end

	a_phase_known: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= i2cram_pkg::P_SP_C)
		else $error("sequencer phase out of range");

	a_read_then_ack: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.read_valid |=> phase_q == i2cram_pkg::P_RA_LOW)
		else $error("received byte not followed by acknowledge phase");

	a_rx_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == i2cram_pkg::P_RX_LOW || phase_q == i2cram_pkg::P_RX_HIGH ||
		 phase_q == i2cram_pkg::P_RA_LOW || phase_q == i2cram_pkg::P_RA_HIGH)
		|-> left_q != 8'd0)
		else $error("read burst running with no bytes left");

	a_err_stop: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(err_q) |-> phase_q == i2cram_pkg::P_SP_A)
		else $error("ack error raised without issuing stop");

endmodule

>>> rtl/i2c_register_access_master.sv
// I2C register access master, one bus tick per accepted word.
// Latency: the result word for a tick is valid the cycle after acceptance.
// Throughput: one word per cycle; the sequencer updates in a single pass and
// the output register only holds off input while a result waits under stall.
// Reset (arst_n low, asynchronous): idle, lines released, delays 60/130, ack limit 250.
// Depends on i2cram_pkg, i2cram_cfg and i2cram_seq.
module i2c_register_access_master #(
	parameter int WAIT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic [1:0]  op,
	input  logic        bus,
	input  logic [7:0]  device_addr,
	input  logic [7:0]  register_addr,
	input  logic [7:0]  write_data,
	input  logic [7:0]  read_count,
	input  logic        sda_in,
	output logic        res_valid,
	input  logic        res_stall,
	output logic        scl,
	output logic        sda_out,
	output logic        sda_drive,
	output logic        bus_sel,
	output logic        read_valid,
	output logic [7:0]  read_data,
	output logic        read_last,
	output logic        ack_error,
	output logic        busy_res,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	i2cram_pkg::cfg_t cfg;
	i2cram_pkg::res_t res;
	i2cram_pkg::res_t res_q;
	logic             res_valid_q;
	logic             step;

	assign cmd_stall = res_valid_q && res_stall;
	assign step      = cmd_valid && !cmd_stall;

	i2cram_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cram_seq #(
		.WAIT_BITS (WAIT_BITS)
	) u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.op            (op),
		.bus           (bus),
		.device_addr   (device_addr),
		.register_addr (register_addr),
		.write_data    (write_data),
		.read_count    (read_count),
		.sda_in        (sda_in),
		.cfg           (cfg),
		.res           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (step) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign res_valid  = res_valid_q;
	assign scl        = res_q.scl;
	assign sda_out    = res_q.sda_out;
	assign sda_drive  = res_q.sda_drive;
	assign bus_sel    = res_q.bus_sel;
	assign read_valid = res_q.read_valid;
	assign read_data  = res_q.read_data;
	assign read_last  = res_q.read_last;
	assign ack_error  = res_q.ack_error;
	assign busy_res   = res_q.busy_res;

endmodule

>>> test/i2cram_checker.sv
// Checker for the I2C register access master: watches the command, result and
// register-write channels, tracks the bus sequencer and compares every result word.
// Depends on i2cram_pkg.
module i2cram_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_stall,
	input  logic [1:0]  op,
	input  logic        bus,
	input  logic [7:0]  device_addr,
	input  logic [7:0]  register_addr,
	input  logic [7:0]  write_data,
	input  logic [7:0]  read_count,
	input  logic        sda_in,
	input  logic        res_valid,
	input  logic        res_stall,
	input  logic        scl,
	input  logic        sda_out,
	input  logic        sda_drive,
	input  logic        bus_sel,
	input  logic        read_valid,
	input  logic [7:0]  read_data,
	input  logic        read_last,
	input  logic        ack_error,
	input  logic        busy_res,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          mismatches,
	output int          words_owed
);

	logic [15:0]      short_wait_q, long_wait_q, wait_q;
	logic [7:0]       ack_limit_q;
	logic [4:0]       phase_q;
	logic [2:0]       bit_q;
	logic [7:0]       shift_q, left_q, polls_q, dev_q, reg_q, data_q;
	logic             bus_q, rd_q, scl_q, sda_q, err_q;
	logic             pres_valid, pres_last;
	logic [7:0]       pres_data;
	i2cram_pkg::res_t levels_due[$];
	i2cram_pkg::res_t head;
	int               fails, result_no;

	function automatic logic [15:0] ticks_of(logic [15:0] v);
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic void enter(logic [4:0] p);
		phase_q = p;
		wait_q = ticks_of(short_wait_q);
		case (p)
			i2cram_pkg::P_ST_A: begin
				scl_q = 1'b1;
				sda_q = 1'b1;
			end
			i2cram_pkg::P_ST_B: sda_q = 1'b0;
			i2cram_pkg::P_ST_C: scl_q = 1'b0;
			i2cram_pkg::P_RS_PRE: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
			end
			i2cram_pkg::P_TX_LOW: begin
				scl_q = 1'b0;
				sda_q = |(shift_q & i2cram_pkg::MSB_MASK);
			end
			i2cram_pkg::P_TX_HIGH: scl_q = 1'b1;
			i2cram_pkg::P_ACK_REL: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
			end
			i2cram_pkg::P_ACK_HIGH: scl_q = 1'b1;
			i2cram_pkg::P_ACK_POLL: begin
				polls_q = 8'd0;
				wait_q = 16'd0;
			end
			i2cram_pkg::P_RX_LOW: begin
				scl_q = 1'b0;
				sda_q = 1'b1;
				wait_q = ticks_of(long_wait_q);
			end
			i2cram_pkg::P_RX_HIGH: scl_q = 1'b1;
			i2cram_pkg::P_RA_LOW: begin
				scl_q = 1'b0;
				sda_q = (left_q == 8'd1);
			end
			i2cram_pkg::P_RA_HIGH: scl_q = 1'b1;
			i2cram_pkg::P_SP_A: begin
				scl_q = 1'b0;
				sda_q = 1'b0;
				wait_q = 16'd1;
			end
			i2cram_pkg::P_SP_B: scl_q = 1'b1;
			i2cram_pkg::P_SP_C: sda_q = 1'b1;
			default: begin
				phase_q = i2cram_pkg::P_IDLE;
				scl_q = 1'b1;
				sda_q = 1'b1;
				wait_q = 16'd0;
			end
		endcase
	endfunction

	function automatic void start_byte_in();
		bit_q = 3'd0;
		shift_q = 8'd0;
		enter(i2cram_pkg::P_RX_LOW);
	endfunction

	// left_q counts stages (device, register, data or read address), then bytes to read
	function automatic void acked();
		if (left_q == 8'd0) begin
			shift_q = reg_q;
			bit_q = 3'd0;
			left_q = 8'd1;
			enter(i2cram_pkg::P_TX_LOW);
		end else if (left_q == 8'd1) begin
			left_q = 8'd2;
			if (rd_q) begin
				enter(i2cram_pkg::P_RS_PRE);
			end else begin
				shift_q = data_q;
				bit_q = 3'd0;
				enter(i2cram_pkg::P_TX_LOW);
			end
		end else if (rd_q) begin
			left_q = (data_q == 8'd0) ? 8'd1 : data_q;
			start_byte_in();
		end else begin
			enter(i2cram_pkg::P_SP_A);
		end
	endfunction

	function automatic void advance(logic s);
		case (phase_q)
			i2cram_pkg::P_ST_A: enter(i2cram_pkg::P_ST_B);
			i2cram_pkg::P_ST_B: enter(i2cram_pkg::P_ST_C);
			i2cram_pkg::P_ST_C: begin
				shift_q = (left_q == 8'd0) ? dev_q : dev_q + 8'd1;
				bit_q = 3'd0;
				enter(i2cram_pkg::P_TX_LOW);
			end
			i2cram_pkg::P_RS_PRE: enter(i2cram_pkg::P_ST_A);
			i2cram_pkg::P_TX_LOW: enter(i2cram_pkg::P_TX_HIGH);
			i2cram_pkg::P_TX_HIGH: begin
				if (bit_q == 3'd7) begin
					enter(i2cram_pkg::P_ACK_REL);
				end else begin
					bit_q = bit_q + 3'd1;
					shift_q = {shift_q[6:0], 1'b0};
					enter(i2cram_pkg::P_TX_LOW);
				end
			end
			i2cram_pkg::P_ACK_REL: enter(i2cram_pkg::P_ACK_HIGH);
			i2cram_pkg::P_ACK_HIGH: enter(i2cram_pkg::P_ACK_POLL);
			i2cram_pkg::P_RX_LOW: enter(i2cram_pkg::P_RX_HIGH);
			i2cram_pkg::P_RX_HIGH: begin
				shift_q = {shift_q[6:0], s};
				if (bit_q == 3'd7) begin
					pres_valid = 1'b1;
					pres_data = shift_q;
					pres_last = (left_q == 8'd1);
					enter(i2cram_pkg::P_RA_LOW);
				end else begin
					bit_q = bit_q + 3'd1;
					enter(i2cram_pkg::P_RX_LOW);
				end
			end
			i2cram_pkg::P_RA_LOW: enter(i2cram_pkg::P_RA_HIGH);
			i2cram_pkg::P_RA_HIGH: begin
				left_q = left_q - 8'd1;
				if (left_q == 8'd0)
					enter(i2cram_pkg::P_SP_A);
				else
					start_byte_in();
			end
			i2cram_pkg::P_SP_A: enter(i2cram_pkg::P_SP_B);
			i2cram_pkg::P_SP_B: enter(i2cram_pkg::P_SP_C);
			default: enter(i2cram_pkg::P_IDLE);
		endcase
	endfunction

	function automatic i2cram_pkg::res_t step_sequencer(logic [1:0] o, logic b,
			logic [7:0] d, r, w, c, logic s);
		i2cram_pkg::res_t lv;
		pres_valid = 1'b0;
		pres_data = 8'd0;
		pres_last = 1'b0;
		if (phase_q == i2cram_pkg::P_IDLE) begin
			if (o == i2cram_pkg::OP_WRITE || o == i2cram_pkg::OP_READ) begin
				bus_q = b;
				dev_q = d;
				reg_q = r;
				rd_q = (o == i2cram_pkg::OP_READ);
				data_q = rd_q ? c : w;
				left_q = 8'd0;
				bit_q = 3'd0;
				err_q = 1'b0;
				enter(i2cram_pkg::P_ST_A);
			end else begin
				scl_q = 1'b1;
				sda_q = 1'b1;
			end
		end else if (phase_q == i2cram_pkg::P_ACK_POLL) begin
			if (!s) begin
				acked();
			end else if (polls_q >= ack_limit_q) begin
				err_q = 1'b1;
				enter(i2cram_pkg::P_SP_A);
			end else begin
				polls_q = polls_q + 8'd1;
			end
		end else if (phase_q > i2cram_pkg::P_SP_C) begin
			enter(i2cram_pkg::P_IDLE);
		end else if (wait_q > 16'd1) begin
			wait_q = wait_q - 16'd1;
		end else begin
			advance(s);
		end
		lv.scl = scl_q;
		lv.sda_out = sda_q;
		lv.sda_drive = !(phase_q == i2cram_pkg::P_ACK_REL ||
			phase_q == i2cram_pkg::P_ACK_HIGH || phase_q == i2cram_pkg::P_ACK_POLL ||
			phase_q == i2cram_pkg::P_RX_LOW || phase_q == i2cram_pkg::P_RX_HIGH);
		lv.bus_sel = bus_q;
		lv.read_valid = pres_valid;
		lv.read_data = pres_data;
		lv.read_last = pres_last;
		lv.ack_error = err_q;
		lv.busy_res = (phase_q != i2cram_pkg::P_IDLE);
		return lv;
	endfunction

	task automatic flag_mismatch(string what, int got, int want);
		fails++;
		$display("mismatch at result word %0d, %s: got %0h, want %0h",
			result_no, what, got, want);
	endtask

	task automatic check_field(string what, int got, int want);
		if (got != want)
			flag_mismatch(what, got, want);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_wait_q = i2cram_pkg::SHORT_WAIT_RST;
			long_wait_q = i2cram_pkg::LONG_WAIT_RST;
			ack_limit_q = i2cram_pkg::ACK_LIMIT_RST;
			phase_q = i2cram_pkg::P_IDLE;
			wait_q = 16'd0;
			bit_q = 3'd0;
			shift_q = 8'd0;
			left_q = 8'd0;
			polls_q = 8'd0;
			bus_q = 1'b0;
			dev_q = 8'd0;
			reg_q = 8'd0;
			data_q = 8'd0;
			rd_q = 1'b0;
			scl_q = 1'b1;
			sda_q = 1'b1;
			err_q = 1'b0;
			levels_due.delete();
			fails = 0;
			result_no = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					i2cram_pkg::CFG_SHORT_WAIT: short_wait_q = cfg_data;
					i2cram_pkg::CFG_LONG_WAIT: long_wait_q = cfg_data;
					i2cram_pkg::CFG_ACK_LIMIT: ack_limit_q = cfg_data[7:0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (levels_due.size() == 0) begin
					flag_mismatch("word with nothing owed", 1, 0);
				end else begin
					head = levels_due.pop_front();
					check_field("scl", scl, head.scl);
					check_field("sda_out", sda_out, head.sda_out);
					check_field("sda_drive", sda_drive, head.sda_drive);
					check_field("bus_sel", bus_sel, head.bus_sel);
					check_field("read_valid", read_valid, head.read_valid);
					check_field("read_data", read_data, head.read_data);
					check_field("read_last", read_last, head.read_last);
					check_field("ack_error", ack_error, head.ack_error);
					check_field("busy_res", busy_res, head.busy_res);
				end
				result_no++;
			end
			if (cmd_valid && !cmd_stall)
				levels_due.push_back(step_sequencer(op, bus, device_addr, register_addr,
					write_data, read_count, sda_in));
		end
		mismatches <= fails;
		words_owed <= levels_due.size();
	end

endmodule

>>> test/tb_i2c_register_access_master.sv
// Testbench top for the I2C register access master: drives bus tick words with a
// randomized slave on SDA, writes the delay registers and gives the verdict.
// Depends on i2cram_pkg, i2cram_checker and the block itself.
module tb_i2c_register_access_master;

	localparam logic [1:0] OP_SPARE  = 2'd3;
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef enum int {SDA_LOW, SDA_EAGER, SDA_COIN, SDA_SHY, SDA_SILENT} slave_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_stall;
	logic [1:0]  op = i2cram_pkg::OP_TICK;
	logic        bus = 1'b0;
	logic [7:0]  device_addr = 8'd0;
	logic [7:0]  register_addr = 8'd0;
	logic [7:0]  write_data = 8'd0;
	logic [7:0]  read_count = 8'd0;
	logic        sda_in = 1'b1;
	logic        res_valid;
	logic        res_stall = 1'b0;
	logic        scl, sda_out, sda_drive, bus_sel, read_valid, read_last, ack_error, busy_res;
	logic [7:0]  read_data;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = i2cram_pkg::CFG_SHORT_WAIT;
	logic [15:0] cfg_data = 16'd0;
	int          mismatches, words_owed;

	int     words_sent = 0;
	int     res_seen = 0;
	logic   last_busy = 1'b0;
	int     gap_pct = 0;
	int     stall_pct = 0;
	int     gap_set[4] = '{0, 45, 0, 15};
	int     stall_set[4] = '{0, 0, 45, 15};
	slave_t slave = SDA_COIN;

	i2c_register_access_master dut (.*);
	i2cram_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk)
		res_stall <= ($urandom_range(99) < stall_pct);

	always @(posedge clk) begin
		if (res_valid && !res_stall) begin
			res_seen <= res_seen + 1;
			last_busy <= busy_res;
		end
	end

	function automatic logic sda_pick();
		case (slave)
			SDA_LOW: return 1'b0;
			SDA_EAGER: return $urandom_range(3) == 0;
			SDA_COIN: return 1'($urandom_range(1));
			SDA_SHY: return $urandom_range(15) != 0;
			default: return 1'b1;
		endcase
	endfunction

	task automatic send_word(logic [1:0] o, logic b, logic [7:0] d, r, w, c);
		while ($urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		op <= o;
		bus <= b;
		device_addr <= d;
		register_addr <= r;
		write_data <= w;
		read_count <= c;
		sda_in <= sda_pick();
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		words_sent++;
	endtask

	task automatic tick();
		send_word(i2cram_pkg::OP_TICK, 1'($urandom_range(1)), 8'($urandom_range(255)),
			8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
	endtask

	// keep ticking until a result word issued after this point shows the bus idle
	task automatic finish_txn();
		int mark;
		mark = words_sent;
		tick();
		while (!(res_seen > mark && !last_busy))
			tick();
	endtask

	task automatic run_txn(logic [1:0] o, logic b, logic [7:0] d, r, w, c, slave_t m);
		slave = m;
		send_word(o, b, d, r, w, c);
		finish_txn();
	endtask

	task automatic random_command();
		int pick;
		logic [1:0] o;
		pick = $urandom_range(19);
		o = (pick < 9) ? i2cram_pkg::OP_WRITE : (pick < 18) ? i2cram_pkg::OP_READ : OP_SPARE;
		send_word(o, 1'($urandom_range(1)), 8'($urandom_range(255)), 8'($urandom_range(255)),
			8'($urandom_range(255)), ($urandom_range(9) == 0) ? 8'($urandom_range(16, 4)) :
			8'($urandom_range(3)));
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		while (res_seen != words_sent)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic load_config(logic [15:0] s, logic [15:0] l, logic [7:0] a);
		write_reg(i2cram_pkg::CFG_SHORT_WAIT, s);
		write_reg(i2cram_pkg::CFG_LONG_WAIT, l);
		write_reg(i2cram_pkg::CFG_ACK_LIMIT, {8'h00, a});
		cfg_valid <= 1'b0;
	endtask

	initial begin
		#5000000;
		$display("i2c_register_access_master test failed");
		$finish;
	end

	initial begin
		int roll;
		int spin;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset delays through the start phases, then short delays for the rest
		slave = SDA_SILENT;
		send_word(i2cram_pkg::OP_WRITE, 1'b0, 8'hA0, 8'h10, 8'h5A, 8'd0);
		repeat (130) tick();
		settle();
		write_reg(CFG_SPARE, 16'hFFFF);
		load_config(16'd0, 16'd0, 8'd0);
		finish_txn();
		run_txn(i2cram_pkg::OP_WRITE, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hFF, SDA_LOW);
		run_txn(i2cram_pkg::OP_WRITE, 1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, SDA_LOW);
		run_txn(i2cram_pkg::OP_READ, 1'b0, 8'hFF, 8'h55, 8'hAA, 8'd0, SDA_LOW);
		run_txn(i2cram_pkg::OP_WRITE, 1'b1, 8'h3C, 8'hC3, 8'h81, 8'd0, SDA_SILENT);
		run_txn(i2cram_pkg::OP_READ, 1'b1, 8'h12, 8'h34, 8'h00, 8'd1, SDA_COIN);
		send_word(OP_SPARE, 1'b1, 8'h66, 8'h99, 8'hF0, 8'h0F);
		// second command lands mid-transaction and must be dropped
		slave = SDA_LOW;
		send_word(i2cram_pkg::OP_WRITE, 1'b0, 8'h42, 8'h24, 8'h18, 8'd0);
		tick();
		tick();
		send_word(i2cram_pkg::OP_READ, 1'b1, 8'hEE, 8'h11, 8'h00, 8'd3);
		finish_txn();
		settle();
		load_config(16'd1, 16'd2, 8'd255);
		run_txn(i2cram_pkg::OP_READ, 1'b1, 8'h00, 8'hFF, 8'h00, 8'd5, SDA_EAGER);
		run_txn(i2cram_pkg::OP_READ, 1'b0, 8'h7F, 8'h80, 8'h00, 8'd2, SDA_SHY);

		for (int ph = 0; ph < 4; ph++) begin
			settle();
			roll = $urandom_range(2);
			load_config(16'($urandom_range(3, 1)), 16'($urandom_range(4)),
				(roll == 0) ? 8'd0 : (roll == 1) ? 8'($urandom_range(8, 1)) :
				8'($urandom_range(255)));
			gap_pct = gap_set[ph];
			stall_pct = stall_set[ph];
			repeat (140) begin
				if (!last_busy && $urandom_range(5) == 0) begin
					roll = $urandom_range(19);
					slave = (roll < 2) ? SDA_LOW : (roll < 10) ? SDA_EAGER :
						(roll < 15) ? SDA_COIN : (roll < 18) ? SDA_SHY : SDA_SILENT;
					random_command();
				end else if ($urandom_range(39) == 0) begin
					random_command();
				end else begin
					tick();
				end
				if ($urandom_range(199) == 0)
					settle();
			end
			finish_txn();
		end

		// top of every delay range; the run ends partway into the read
		settle();
		load_config(16'hFFFF, 16'hFFFF, 8'hFF);
		slave = SDA_EAGER;
		send_word(i2cram_pkg::OP_READ, 1'b1, 8'hC0, 8'h3F, 8'h00, 8'd4);
		repeat (40) tick();

		cmd_valid <= 1'b0;
		spin = 0;
		while (res_seen != words_sent && spin < 1000) begin
			@(posedge clk);
			spin++;
		end
		repeat (10) @(posedge clk);
		if (mismatches == 0 && words_owed == 0)
			$display("i2c_register_access_master test passed");
		else
			$display("i2c_register_access_master test failed");
		$finish;
	end

endmodule
